[hdl/gwvg_pkg.sv]
// Shared types, constants and fixed-point helpers for the waypoint guidance core.
// No dependencies; every other file in hdl/ but gwvg_if.sv refers to this package by scoped name.
package gwvg_pkg;

  // Stages of the restoring square root: one per result bit, for radicands below 2^62.
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned SQRT_W      = 62;

  localparam logic signed [33:0] HALF_TURN_E7 = 34'sd1800000000;
  localparam logic signed [33:0] TURN_E7      = 34'sd3600000000;
  localparam logic signed [31:0] E7_TO_BAM    = 32'sd1281023894;
  localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN_B  = 34'sd2147483648;
  localparam logic [32:0]        RANGE_SCALE  = 33'd8006034718;
  localparam logic [30:0]        RANGE_MAX    = 31'd2001600000;
  localparam logic [15:0]        CDEG_TURN    = 16'd36000;
  localparam logic signed [21:0] ALT_BAND_CM  = 22'sd100;

  typedef enum logic [2:0] {
    REG_TARGET_LAT    = 3'd0,
    REG_TARGET_LON    = 3'd1,
    REG_TARGET_ALT    = 3'd2,
    REG_ARRIVAL_RAD   = 3'd3,
    REG_SPEED_LIMIT   = 3'd4,
    REG_CLIMB_LIMIT   = 3'd5
  } cfg_reg_e;

  typedef logic signed [33:0] q30_t;

  typedef struct packed {
    logic signed [14:0] down;
    logic               near;
  } alt_side_t;

  typedef struct packed {
    logic [30:0] range;
    logic [15:0] cdeg;
    logic [14:0] speed;
  } range_side_t;

  // Arctangent of 2^-i in binary angle units (2^32 per turn).
  localparam logic signed [33:0] ATAN_BAM [32] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
    34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
    34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051,
    34'sh000000029, 34'sh000000014, 34'sh00000000A, 34'sh000000005,
    34'sh000000003, 34'sh000000001, 34'sh000000001, 34'sh000000000
  };

  // Q30 product, rounded half up.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  // Fold a difference of degree*1e7 values into [-180, 180) degrees.
  function automatic logic signed [31:0] wrap_e7(input logic signed [33:0] d);
    logic signed [33:0] r;
    r = d;
    if (d >= HALF_TURN_E7) begin
      r = d - TURN_E7;
    end else if (d < -HALF_TURN_E7) begin
      r = d + TURN_E7;
    end
    return r[31:0];
  endfunction

  // Degree*1e7 to binary angle, rounded half up, modulo one turn.
  function automatic logic [31:0] e7_to_bam(input logic signed [31:0] r);
    logic signed [63:0] p;
    p = r * E7_TO_BAM;
    p = p + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

[hdl/gwvg_if.sv]
// Valid/ready channel interfaces for position fixes and velocity setpoints.
// Depends on nothing; the core and the checker use the fields by name.
interface gwvg_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] cur_lat;
  logic signed [31:0] cur_lon;
  logic signed [20:0] cur_alt_cm;

  modport source(output valid, output cur_lat, output cur_lon, output cur_alt_cm,
                 input ready);
  modport sink(input valid, input cur_lat, input cur_lon, input cur_alt_cm,
               output ready);
endinterface

interface gwvg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] north_mms;
  logic signed [15:0] east_mms;
  logic signed [14:0] down_mms;
  logic [15:0]        heading_cdeg;
  logic [30:0]        range_cm;
  logic               arrived;

  modport source(output valid, output north_mms, output east_mms, output down_mms,
                 output heading_cdeg, output range_cm, output arrived, input ready);
  modport sink(input valid, input north_mms, input east_mms, input down_mms,
               input heading_cdeg, input range_cm, input arrived, output ready);
endinterface

[hdl/gwvg_rot.sv]
// Pipelined CORDIC rotator: binary angle in, Q30 cosine and sine out.
// Depends on gwvg_pkg. An input register feeds STAGES iteration registers; the final negation is combinational.
module gwvg_rot #(
  parameter int unsigned STAGES = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        ang_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [33:0] x_q [STAGES+1];
  logic signed [33:0] y_q [STAGES+1];
  logic signed [33:0] z_q [STAGES+1];
  logic               neg_q [STAGES+1];
  logic signed [33:0] z_d;
  logic               neg_d;
  logic signed [33:0] x_out;
  logic signed [33:0] y_out;

  // Angles beyond a quarter turn are turned by half a turn; the result is negated later.
  always_comb begin
    z_d   = 34'(signed'(ang_i));
    neg_d = 1'b0;
    if (z_d > gwvg_pkg::Q30_ONE) begin
      z_d   = z_d - gwvg_pkg::HALF_TURN_B;
      neg_d = 1'b1;
    end else if (z_d < -gwvg_pkg::Q30_ONE) begin
      z_d   = z_d + gwvg_pkg::HALF_TURN_B;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= gwvg_pkg::CORDIC_K;
      y_q[0]   <= '0;
      z_q[0]   <= z_d;
      neg_q[0] <= neg_d;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gwvg_pkg::ATAN_BAM[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gwvg_pkg::ATAN_BAM[i];
        end
      end
    end
  end

  assign x_out = neg_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
  assign y_out = neg_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
  assign cos_o = x_out[31:0];
  assign sin_o = y_out[31:0];

endmodule

[hdl/gwvg_vec.sv]
// Pipelined CORDIC vectoring unit: atan2(y, x) as a binary angle.
// Depends on gwvg_pkg. An input register feeds STAGES iteration registers; a zero vector gives 0.
module gwvg_vec #(
  parameter int unsigned STAGES = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] y_i,
  input  logic signed [33:0] x_i,
  output logic [31:0]        ang_o
);

  logic signed [35:0] x_q [STAGES+1];
  logic signed [35:0] y_q [STAGES+1];
  logic [31:0]        z_q [STAGES+1];
  logic               zero_q [STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (y_i == '0) && (x_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -36'(x_i);
        y_q[0] <= -36'(y_i);
        z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= 36'(x_i);
        y_q[0] <= 36'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gwvg_pkg::ATAN_BAM[i][31:0];
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gwvg_pkg::ATAN_BAM[i][31:0];
        end
      end
    end
  end

  assign ang_o = zero_q[STAGES] ? '0 : z_q[STAGES];

endmodule

[hdl/gwvg_sqrt.sv]
// Pipelined restoring square root of a Q30 value, one result bit per stage.
// Depends on gwvg_pkg. Each of the SQRT_STAGES stages ends in a register.
module gwvg_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] a_i,
  output logic [30:0] r_o
);

  localparam int unsigned N = gwvg_pkg::SQRT_STAGES;
  localparam int unsigned W = gwvg_pkg::SQRT_W;

  logic [W-1:0] v_in [N];
  logic [W-1:0] r_in [N];
  logic [W-1:0] v_q  [N];
  logic [W-1:0] r_q  [N];

  // The radicand is a << 30, so its root is again in Q30.
  assign v_in[0] = W'({a_i, 30'b0});
  assign r_in[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_bit
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - j));
    logic [W-1:0] rb;

    if (j > 0) begin : g_link
      assign v_in[j] = v_q[j-1];
      assign r_in[j] = r_q[j-1];
    end

    assign rb = r_in[j] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in[j] >= rb) begin
          v_q[j] <= v_in[j] - rb;
          r_q[j] <= (r_in[j] >> 1) + BIT;
        end else begin
          v_q[j] <= v_in[j];
          r_q[j] <= r_in[j] >> 1;
        end
      end
    end
  end

  assign r_o = r_q[N-1][30:0];

endmodule

[hdl/gps_waypoint_velocity_guidance_core.sv]
// Waypoint guidance core: haversine range, bearing and velocity setpoints per position fix.
// Depends on gwvg_pkg, gwvg_if, gwvg_rot, gwvg_vec and gwvg_sqrt.
//
//   Channel  | Direction | Handshake          | Carries
//   in_i     | sink      | valid / ready      | cur_lat, cur_lon, cur_alt_cm
//   out_o    | source    | valid / ready      | north, east, down, heading, range, arrived
//   cfg      | sink      | cfg_we_i only      | cfg_idx_i selects register, cfg_data_i
//
// One item enters per cycle while the output is not stalled. The pipeline is made up of
// three CORDIC chains in series, the 31-stage square root and the multiplies.
// The whole pipeline advances together; when the output item is not taken every stage
// holds, and in_i.ready is low in that cycle. Reset clears the valid bits and loads the
// register reset values; data stages are not reset.
module gps_waypoint_velocity_guidance_core #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gwvg_in_if.sink     in_i,
  gwvg_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned L       = CORDIC_STAGES;
  localparam int unsigned T_WRAP  = 2;
  localparam int unsigned T_BAM   = 3;
  localparam int unsigned T_ROT   = T_BAM + 1 + L;
  localparam int unsigned T_P3    = T_ROT + 3;
  localparam int unsigned T_SQ    = T_P3 + gwvg_pkg::SQRT_STAGES;
  localparam int unsigned T_HV    = T_SQ + 1 + L;
  localparam int unsigned T_FR    = T_HV + 1 + L;
  localparam int unsigned T_OUT   = T_FR + 1;
  localparam int unsigned BRG_DLY = gwvg_pkg::SQRT_STAGES + 1;
  localparam int unsigned RG_DLY  = L;
  localparam int unsigned ALT_DLY = T_FR - T_WRAP + 1;

  // Configuration registers
  logic signed [30:0] tgt_lat_q;
  logic signed [31:0] tgt_lon_q;
  logic signed [20:0] tgt_alt_q;
  logic [16:0]        radius_q;
  logic [14:0]        spd_lim_q;
  logic [13:0]        clb_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lat_q <= '0;
      tgt_lon_q <= '0;
      tgt_alt_q <= 21'sd1000;
      radius_q  <= 17'd500;
      spd_lim_q <= 15'd2000;
      clb_lim_q <= 14'd1000;
    end else if (cfg_we_i) begin
      unique case (gwvg_pkg::cfg_reg_e'(cfg_idx_i))
        gwvg_pkg::REG_TARGET_LAT:  tgt_lat_q <= cfg_data_i[30:0];
        gwvg_pkg::REG_TARGET_LON:  tgt_lon_q <= cfg_data_i;
        gwvg_pkg::REG_TARGET_ALT:  tgt_alt_q <= cfg_data_i[20:0];
        gwvg_pkg::REG_ARRIVAL_RAD: radius_q  <= cfg_data_i[16:0];
        gwvg_pkg::REG_SPEED_LIMIT: spd_lim_q <= cfg_data_i[14:0];
        gwvg_pkg::REG_CLIMB_LIMIT: clb_lim_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic [T_OUT-1:0] vld_q;
  logic             en;

  assign en         = !vld_q[T_OUT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_OUT-2:0], in_i.valid};
    end
  end

  // Stage 1: input capture
  logic signed [30:0] lat1_q;
  logic signed [31:0] lon1_q;
  logic signed [20:0] alt1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= in_i.cur_lat;
      lon1_q <= in_i.cur_lon;
      alt1_q <= in_i.cur_alt_cm;
    end
  end

  // Stage 2: angle folding and the altitude loop
  logic signed [31:0] r_lat1_q, r_lat2_q, r_dlat_q, r_dlon_q;
  logic signed [21:0] err;
  logic signed [24:0] err5, lim, dn;
  gwvg_pkg::alt_side_t alt_d;
  gwvg_pkg::alt_side_t alt_q [ALT_DLY];

  always_comb begin
    err  = 22'(tgt_alt_q) - 22'(alt1_q);
    err5 = 25'(err) * 25'sd5;
    lim  = $signed(25'(clb_lim_q));
    dn   = err5;
    if (err5 > lim) begin
      dn = lim;
    end else if (err5 < -lim) begin
      dn = -lim;
    end
    dn         = -dn;
    alt_d.down = dn[14:0];
    alt_d.near = (err > -gwvg_pkg::ALT_BAND_CM) && (err < gwvg_pkg::ALT_BAND_CM);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_lat1_q <= gwvg_pkg::wrap_e7(34'(lat1_q));
      r_lat2_q <= gwvg_pkg::wrap_e7(34'(tgt_lat_q));
      r_dlat_q <= gwvg_pkg::wrap_e7(34'(tgt_lat_q) - 34'(lat1_q));
      r_dlon_q <= gwvg_pkg::wrap_e7(34'(tgt_lon_q) - 34'(lon1_q));
      alt_q[0] <= alt_d;
      for (int k = 1; k < ALT_DLY; k++) begin
        alt_q[k] <= alt_q[k-1];
      end
    end
  end

  // Stage 3: binary angles
  logic [31:0] b_lat1_q, b_lat2_q, b_dlat_q, b_dlon_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_lat1_q <= gwvg_pkg::e7_to_bam(r_lat1_q);
      b_lat2_q <= gwvg_pkg::e7_to_bam(r_lat2_q);
      b_dlat_q <= gwvg_pkg::e7_to_bam(r_dlat_q);
      b_dlon_q <= gwvg_pkg::e7_to_bam(r_dlon_q);
    end
  end

  // Five rotators in parallel
  logic signed [31:0] c1, s1, c2, s2, cdl, sdl, chl, shl, chn, shn;

  gwvg_rot #(.STAGES(L)) u_rot_lat1 (
    .clk_i(clk_i), .en_i(en), .ang_i(b_lat1_q), .cos_o(c1), .sin_o(s1));
  gwvg_rot #(.STAGES(L)) u_rot_lat2 (
    .clk_i(clk_i), .en_i(en), .ang_i(b_lat2_q), .cos_o(c2), .sin_o(s2));
  gwvg_rot #(.STAGES(L)) u_rot_dlon (
    .clk_i(clk_i), .en_i(en), .ang_i(b_dlon_q), .cos_o(cdl), .sin_o(sdl));
  gwvg_rot #(.STAGES(L)) u_rot_hlat (
    .clk_i(clk_i), .en_i(en), .ang_i(b_dlat_q >> 1), .cos_o(chl), .sin_o(shl));
  gwvg_rot #(.STAGES(L)) u_rot_hlon (
    .clk_i(clk_i), .en_i(en), .ang_i(b_dlon_q >> 1), .cos_o(chn), .sin_o(shn));

  // Products: haversine term and bearing vector
  gwvg_pkg::q30_t t_q, a1_q, yb_q, u1_q, vv_q, c1_q, c2_q, cdl_q;
  gwvg_pkg::q30_t w_q, xb_q, a1_p2_q, c2_p2_q, yb_p2_q;
  logic signed [34:0] a_sum;
  logic [30:0]        a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q   <= gwvg_pkg::mulq(gwvg_pkg::q30_t'(shn), gwvg_pkg::q30_t'(shn));
      a1_q  <= gwvg_pkg::mulq(gwvg_pkg::q30_t'(shl), gwvg_pkg::q30_t'(shl));
      yb_q  <= gwvg_pkg::mulq(gwvg_pkg::q30_t'(sdl), gwvg_pkg::q30_t'(c2));
      u1_q  <= gwvg_pkg::mulq(gwvg_pkg::q30_t'(c1), gwvg_pkg::q30_t'(s2));
      vv_q  <= gwvg_pkg::mulq(gwvg_pkg::q30_t'(s1), gwvg_pkg::q30_t'(c2));
      c1_q  <= gwvg_pkg::q30_t'(c1);
      c2_q  <= gwvg_pkg::q30_t'(c2);
      cdl_q <= gwvg_pkg::q30_t'(cdl);

      w_q     <= gwvg_pkg::mulq(t_q, c1_q);
      xb_q    <= u1_q - gwvg_pkg::mulq(vv_q, cdl_q);
      a1_p2_q <= a1_q;
      c2_p2_q <= c2_q;
      yb_p2_q <= yb_q;
    end
  end

  assign a_sum = 35'(a1_p2_q) + 35'(gwvg_pkg::mulq(w_q, c2_p2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 35'(gwvg_pkg::Q30_ONE)) begin
        a_q <= gwvg_pkg::Q30_ONE[30:0];
      end else begin
        a_q <= a_sum[30:0];
      end
    end
  end

  // Bearing from the vector, delayed to meet the range path
  logic [31:0] brg_raw;
  logic [31:0] brg_q [BRG_DLY];

  gwvg_vec #(.STAGES(L)) u_vec_brg (
    .clk_i(clk_i), .en_i(en), .y_i(yb_p2_q), .x_i(xb_q), .ang_o(brg_raw));

  always_ff @(posedge clk_i) begin
    if (en) begin
      brg_q[0] <= brg_raw;
      for (int k = 1; k < BRG_DLY; k++) begin
        brg_q[k] <= brg_q[k-1];
      end
    end
  end

  // Half central angle
  logic [30:0] sa, sc;
  logic [31:0] hv_ang;

  gwvg_sqrt u_sqrt_a (.clk_i(clk_i), .en_i(en), .a_i(a_q), .r_o(sa));
  gwvg_sqrt u_sqrt_c (
    .clk_i(clk_i), .en_i(en), .a_i(gwvg_pkg::Q30_ONE[30:0] - a_q), .r_o(sc));

  gwvg_vec #(.STAGES(L)) u_vec_hav (
    .clk_i(clk_i), .en_i(en), .y_i(34'(sa)), .x_i(34'(sc)), .ang_o(hv_ang));

  // Range, heading and speed
  logic [30:0] h_clamp;
  logic [63:0] hp_q;
  logic [47:0] cdp_q;
  logic [63:0] rng_sum;
  logic [31:0] rng_raw;
  logic [30:0] rng;
  logic [31:0] rng2;
  gwvg_pkg::range_side_t rg_d;
  gwvg_pkg::range_side_t rg_q [RG_DLY];

  always_comb begin
    if (hv_ang[31]) begin
      h_clamp = '0;
    end else if (hv_ang[30:0] > gwvg_pkg::Q30_ONE[30:0]) begin
      h_clamp = gwvg_pkg::Q30_ONE[30:0];
    end else begin
      h_clamp = hv_ang[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hp_q  <= 64'(h_clamp) * 64'(gwvg_pkg::RANGE_SCALE);
      cdp_q <= 48'(brg_q[BRG_DLY-1]) * 48'(gwvg_pkg::CDEG_TURN) + 48'h8000_0000;
    end
  end

  always_comb begin
    rng_sum = hp_q + 64'h8000_0000;
    rng_raw = rng_sum[63:32];
    rng     = (rng_raw > 32'(gwvg_pkg::RANGE_MAX)) ? gwvg_pkg::RANGE_MAX : rng_raw[30:0];
    rng2    = {rng, 1'b0};
    rg_d.range = rng;
    rg_d.cdeg  = (cdp_q[47:32] >= gwvg_pkg::CDEG_TURN) ? '0 : cdp_q[47:32];
    rg_d.speed = (rng2 > 32'(spd_lim_q)) ? spd_lim_q : rng2[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rg_q[0] <= rg_d;
      for (int k = 1; k < RG_DLY; k++) begin
        rg_q[k] <= rg_q[k-1];
      end
    end
  end

  // Velocity split along the bearing
  logic signed [31:0] cb, sb;

  gwvg_rot #(.STAGES(L)) u_rot_brg (
    .clk_i(clk_i), .en_i(en), .ang_i(brg_q[BRG_DLY-1]), .cos_o(cb), .sin_o(sb));

  gwvg_pkg::range_side_t rg_f;
  gwvg_pkg::alt_side_t   alt_f;
  logic signed [47:0]    pn, pe;
  logic                  arr;

  assign rg_f  = rg_q[RG_DLY-1];
  assign alt_f = alt_q[ALT_DLY-1];
  assign pn    = $signed({1'b0, rg_f.speed}) * cb + 48'sd536870912;
  assign pe    = $signed({1'b0, rg_f.speed}) * sb + 48'sd536870912;
  assign arr   = (rg_f.range < 31'(radius_q)) && alt_f.near;

  logic signed [15:0] north_q, east_q;
  logic signed [14:0] down_q;
  logic [15:0]        hdg_q;
  logic [30:0]        range_q;
  logic               arr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      north_q <= arr ? '0 : pn[45:30];
      east_q  <= arr ? '0 : pe[45:30];
      down_q  <= arr ? '0 : alt_f.down;
      hdg_q   <= rg_f.cdeg;
      range_q <= rg_f.range;
      arr_q   <= arr;
    end
  end

  assign out_o.valid        = vld_q[T_OUT-1];
  assign out_o.north_mms    = north_q;
  assign out_o.east_mms     = east_q;
  assign out_o.down_mms     = down_q;
  assign out_o.heading_cdeg = hdg_q;
  assign out_o.range_cm     = range_q;
  assign out_o.arrived      = arr_q;

endmodule

[hdl/gwvg_chk.sv]
// Port-level checker for the waypoint guidance core, attached by bind.
// Depends on gwvg_pkg and on the ports of gps_waypoint_velocity_guidance_core.
module gwvg_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] north_i,
  input logic signed [15:0] east_i,
  input logic signed [14:0] down_i,
  input logic [15:0]        hdg_i,
  input logic [30:0]        range_i,
  input logic               arrived_i
);

  // The pipeline takes an item exactly when its output stage can move.
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the output stage");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(north_i) && $stable(east_i)
      && $stable(down_i) && $stable(hdg_i) && $stable(range_i) && $stable(arrived_i))
    else $error("stalled output item changed");

  a_arrived_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && arrived_i |-> north_i == '0 && east_i == '0 && down_i == '0)
    else $error("arrived item carries a nonzero velocity");

  a_out_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> hdg_i < gwvg_pkg::CDEG_TURN && range_i <= gwvg_pkg::RANGE_MAX)
    else $error("heading or range out of range");

endmodule

bind gps_waypoint_velocity_guidance_core gwvg_chk u_gwvg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .north_i     (out_o.north_mms),
  .east_i      (out_o.east_mms),
  .down_i      (out_o.down_mms),
  .hdg_i       (out_o.heading_cdeg),
  .range_i     (out_o.range_cm),
  .arrived_i   (out_o.arrived)
);
